>>> hdl/skf_pkg.sv
`timescale 1ns / 1ps
// Shared widths, types, reset values and register indexes of the scalar Kalman filter.
package skf_pkg;

  localparam int DATA_WIDTH = 32;
  localparam int FRAC_BITS  = 16;

  // Gain is Q0.FRAC_BITS with one extra bit so that 1.0 is representable.
  localparam int GAIN_W  = FRAC_BITS + 1;
  // Magnitude of a difference of two signed data words.
  localparam int MAG_W   = DATA_WIDTH + 1;
  localparam int CFG_IDX_W = 2;

  localparam int DIV_CNT_W = $clog2(FRAC_BITS + 2);
  localparam int MUL_CNT_W = $clog2(FRAC_BITS + 1);

  typedef logic [DATA_WIDTH-1:0] data_t;
  typedef logic [GAIN_W-1:0]     gain_t;
  typedef logic [MAG_W-1:0]      mag_t;
  typedef logic [CFG_IDX_W-1:0]  cfg_idx_t;

  localparam gain_t GAIN_ONE = gain_t'(64'(1) << FRAC_BITS);

  // Reset values: Q is about 0.01, R and P0 are 1.0, x0 is 0.
  localparam data_t Q_RESET  = data_t'(((64'(1) << FRAC_BITS) * 64'(655)) >> 16);
  localparam data_t R_RESET  = data_t'(64'(1) << FRAC_BITS);
  localparam data_t X0_RESET = '0;
  localparam data_t P0_RESET = data_t'(64'(1) << FRAC_BITS);

  localparam cfg_idx_t REG_PROCESS_NOISE      = 2'd0;
  localparam cfg_idx_t REG_MEASUREMENT_NOISE  = 2'd1;
  localparam cfg_idx_t REG_INITIAL_ESTIMATE   = 2'd2;
  localparam cfg_idx_t REG_INITIAL_COVARIANCE = 2'd3;

endpackage

>>> hdl/skf_in_if.sv
`timescale 1ns / 1ps
// Measurement channel: valid/ready handshake with one signed sample per transfer.
interface skf_in_if;
  import skf_pkg::*;

  logic  valid;
  logic  ready;
  data_t measurement;

  modport source (output valid, output measurement, input ready);
  modport sink (input valid, input measurement, output ready);
endinterface

>>> hdl/skf_out_if.sv
`timescale 1ns / 1ps
// Result channel: valid/ready handshake carrying the filtered value and the gain used.
interface skf_out_if;
  import skf_pkg::*;

  logic  valid;
  logic  ready;
  data_t filtered_value;
  gain_t kalman_gain;

  modport source (output valid, output filtered_value, output kalman_gain, input ready);
  modport sink (input valid, input filtered_value, input kalman_gain, output ready);
endinterface

>>> hdl/scalar_kalman_filter.sv
`timescale 1ns / 1ps
// Top level of the scalar Kalman filter: control, state registers and output register.
//
// Usage: each transfer on in_ch carries one signed Q16.16 measurement. For every
// measurement exactly one result leaves on out_ch: the updated estimate and the gain
// (unsigned Q1.16, 65536 = 1.0) that produced it.
// The configuration port writes Q, R, the initial estimate and the initial covariance
// (indexes 0 to 3); writing either initial value also loads the running state. Write
// it only while no measurement is in flight.
// The division dominates the processing of a measurement: it resolves one gain bit per
// cycle (FRAC_BITS + 2 steps), followed by two shift-add multipliers that run side by
// side over the FRAC_BITS + 1 gain bits.
// Throughput: one measurement at a time; in_ch.ready is high only while the block is idle,
// so a new measurement can be taken in the cycle after the previous result is registered.
// Stall: the result sits in an output register. The block accepts the next measurement
// while that result waits; if the receiver still has not taken it when the next result is
// finished, the block holds that result internally until out_ch.ready.
// Reset (synchronous, active low) restores the register defaults, loads estimate 0 and
// covariance 1.0, and empties the output register.
module scalar_kalman_filter (
  input  logic               clk,
  input  logic               rst_n,
  skf_in_if.sink             in_ch,
  skf_out_if.source          out_ch,
  input  logic               cfg_we,
  input  skf_pkg::cfg_idx_t  cfg_index,
  input  skf_pkg::data_t     cfg_wdata
);
  import skf_pkg::*;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_PRED = 3'd1;
  localparam logic [2:0] S_LOAD = 3'd2;
  localparam logic [2:0] S_DIV  = 3'd3;
  localparam logic [2:0] S_MUL  = 3'd4;
  localparam logic [2:0] S_DONE = 3'd5;

  logic [2:0] state_r, state_nxt;

  // Configuration and filter state.
  data_t q_r, r_r;
  data_t est_r, cov_r;

  // Per-measurement working registers.
  data_t meas_r;
  data_t pp_r;
  mag_t  mag_r;
  logic  neg_r;

  // Output register.
  logic  out_valid_r;
  data_t out_est_r;
  gain_t out_gain_r;

  logic                  in_xfer;
  logic [DATA_WIDTH:0]   pred_sum;
  data_t                 pp_sat;
  logic [DATA_WIDTH:0]   diff;
  logic [DATA_WIDTH:0]   den;
  logic                  div_start, div_done;
  gain_t                 gain;
  logic                  mul_start, mul_done_corr, mul_done_cov;
  mag_t                  corr, cov_prod;
  logic [DATA_WIDTH+1:0] est_ext, est_sum;
  logic                  out_load;

  assign in_xfer = in_ch.valid && in_ch.ready;

  // Predicted covariance P + Q, saturated at the largest unsigned value.
  assign pred_sum = {1'b0, cov_r} + {1'b0, q_r};
  assign pp_sat   = pred_sum[DATA_WIDTH] ? '1 : pred_sum[DATA_WIDTH-1:0];

  // Innovation, kept as sign and magnitude so that the multiplier stays unsigned.
  assign diff = {meas_r[DATA_WIDTH-1], meas_r} - {est_r[DATA_WIDTH-1], est_r};

  // The gain denominator is the full unsaturated sum of Pp and R.
  assign den = {1'b0, pp_r} + {1'b0, r_r};

  assign div_start = (state_r == S_LOAD);
  assign mul_start = (state_r == S_DIV) && div_done;

  skf_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .num   (pp_r),
    .den   (den),
    .done  (div_done),
    .gain  (gain)
  );

  // Correction magnitude |z - x| * K.
  skf_mul u_mul_corr (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (mul_start),
    .a      (mag_r),
    .b      (gain),
    .done   (mul_done_corr),
    .result (corr)
  );

  // New covariance (1 - K) * Pp.
  skf_mul u_mul_cov (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (mul_start),
    .a      ({1'b0, pp_r}),
    .b      (GAIN_ONE - gain),
    .done   (mul_done_cov),
    .result (cov_prod)
  );

  // The correction never exceeds the innovation, so the estimate stays in range.
  assign est_ext = {est_r[DATA_WIDTH-1], est_r[DATA_WIDTH-1], est_r};
  assign est_sum = neg_r ? (est_ext - {1'b0, corr}) : (est_ext + {1'b0, corr});

  assign out_load = (state_r == S_DONE) && (!out_valid_r || out_ch.ready);

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: if (in_xfer) state_nxt = S_PRED;
      S_PRED: state_nxt = S_LOAD;
      S_LOAD: state_nxt = S_DIV;
      S_DIV:  if (div_done) state_nxt = S_MUL;
      S_MUL:  if (mul_done_corr) state_nxt = S_DONE;
      S_DONE: if (out_load) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      q_r         <= Q_RESET;
      r_r         <= R_RESET;
      est_r       <= X0_RESET;
      cov_r       <= P0_RESET;
    end else begin
      state_r <= state_nxt;

      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end

      if ((state_r == S_MUL) && mul_done_corr) begin
        est_r <= est_sum[DATA_WIDTH-1:0];
        cov_r <= cov_prod[DATA_WIDTH-1:0];
      end

      if (cfg_we) begin
        case (cfg_index)
          REG_PROCESS_NOISE:      q_r <= cfg_wdata;
          REG_MEASUREMENT_NOISE:  r_r <= cfg_wdata;
          REG_INITIAL_ESTIMATE:   est_r <= cfg_wdata;
          REG_INITIAL_COVARIANCE: cov_r <= cfg_wdata;
          default: ;
        endcase
      end
    end
  end

  // Datapath registers without reset.
  always_ff @(posedge clk) begin
    if (in_xfer) begin
      meas_r <= in_ch.measurement;
    end
    if (state_r == S_PRED) begin
      pp_r  <= pp_sat;
      neg_r <= diff[DATA_WIDTH];
      mag_r <= diff[DATA_WIDTH] ? (~diff + 1'b1) : diff;
    end
    if (out_load) begin
      out_est_r  <= est_r;
      out_gain_r <= gain;
    end
  end

  assign in_ch.ready           = (state_r == S_IDLE);
  assign out_ch.valid          = out_valid_r;
  assign out_ch.filtered_value = out_est_r;
  assign out_ch.kalman_gain    = out_gain_r;

  // The two multipliers start together and must finish together.
  a_mul_lockstep: assert property (@(posedge clk) disable iff (!rst_n)
    mul_done_corr == mul_done_cov)
    else $error("multipliers out of step");

  // The divider only reports completion while the sequencer waits for it.
  a_div_done_state: assert property (@(posedge clk) disable iff (!rst_n)
    div_done |-> (state_r == S_DIV))
    else $error("divider done outside division phase");

  // The gain never exceeds 1.0 once the division has finished.
  a_gain_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_MUL) |-> (gain <= GAIN_ONE))
    else $error("gain above one");

  // The updated covariance never exceeds the predicted covariance.
  a_cov_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DONE) |-> (cov_prod <= {1'b0, pp_r}))
    else $error("covariance grew in update");

  // A measurement transfer always leads straight into the prediction step.
  a_accept_pred: assert property (@(posedge clk) disable iff (!rst_n)
    in_xfer |=> (state_r == S_PRED))
    else $error("accepted measurement not processed");

endmodule

>>> hdl/skf_div.sv
`timescale 1ns / 1ps
// Restoring divider producing the rounded gain one quotient bit per cycle.
module skf_div (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  input  skf_pkg::data_t                num,
  input  logic [skf_pkg::DATA_WIDTH:0]  den,
  output logic                          done,
  output skf_pkg::gain_t                gain
);
  import skf_pkg::*;

  logic [DATA_WIDTH+1:0] rem_r, rem_nxt, trial;
  logic [DATA_WIDTH:0]   den_r;
  logic [FRAC_BITS+1:0]  quo_r;
  logic [FRAC_BITS+2:0]  quo_inc;
  logic [DIV_CNT_W-1:0]  cnt_r;
  logic                  busy_r, first_r, zero_r, done_r;
  logic                  ge;

  // The first step compares the unshifted numerator to get the integer bit.
  always_comb begin
    trial   = first_r ? rem_r : {rem_r[DATA_WIDTH:0], 1'b0};
    ge      = trial >= {1'b0, den_r};
    rem_nxt = ge ? (trial - {1'b0, den_r}) : trial;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r  <= 1'b0;
      done_r  <= 1'b0;
      first_r <= 1'b0;
      cnt_r   <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r  <= 1'b1;
        first_r <= 1'b1;
        cnt_r   <= '0;
      end else if (busy_r) begin
        first_r <= 1'b0;
        cnt_r   <= cnt_r + 1'b1;
        if (cnt_r == DIV_CNT_W'(FRAC_BITS + 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem_r  <= {2'b00, num};
      den_r  <= den;
      quo_r  <= '0;
      zero_r <= (den == '0);
    end else if (busy_r) begin
      rem_r <= rem_nxt;
      quo_r <= {quo_r[FRAC_BITS:0], ge};
    end
  end

  // Round to nearest, ties up, by dropping the extra quotient bit after adding one.
  assign quo_inc = {1'b0, quo_r} + (FRAC_BITS + 3)'(1);
  assign gain    = zero_r ? '0 : quo_inc[FRAC_BITS+1:1];
  assign done    = done_r;

endmodule

>>> hdl/skf_mul.sv
`timescale 1ns / 1ps
// Shift-add multiplier, one multiplier bit per cycle, result shifted right by FRAC_BITS and rounded to nearest.
module skf_mul (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           start,
  input  skf_pkg::mag_t  a,
  input  skf_pkg::gain_t b,
  output logic           done,
  output skf_pkg::mag_t  result
);
  import skf_pkg::*;

  logic [DATA_WIDTH+1:0] acc_r, sum;
  logic [FRAC_BITS:0]    lo_r;
  gain_t                 b_r;
  mag_t                  a_r;
  logic [MUL_CNT_W-1:0]  cnt_r;
  logic                  busy_r, done_r;
  logic [DATA_WIDTH+2:0] rounded;

  assign sum = acc_r + (b_r[0] ? {1'b0, a_r} : '0);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == MUL_CNT_W'(FRAC_BITS)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  // Low product bits shift out of the accumulator into lo_r.
  always_ff @(posedge clk) begin
    if (start) begin
      acc_r <= '0;
      lo_r  <= '0;
      a_r   <= a;
      b_r   <= b;
    end else if (busy_r) begin
      acc_r <= {1'b0, sum[DATA_WIDTH+1:1]};
      lo_r  <= {sum[0], lo_r[FRAC_BITS:1]};
      b_r   <= b_r >> 1;
    end
  end

  // Product shifted right by FRAC_BITS plus the rounding bit (ties up).
  assign rounded = {acc_r, lo_r[FRAC_BITS]} + (DATA_WIDTH + 3)'(lo_r[FRAC_BITS-1]);
  assign result  = rounded[DATA_WIDTH:0];
  assign done    = done_r;

endmodule
